>>> rtl/lfys_pkg.sv
package lfys_pkg;

    localparam int unsigned SEED_W = 32;
    localparam int unsigned POS_W  = 11;
    localparam int unsigned CMD_W  = 2;

    localparam logic [SEED_W-1:0] LCG_MULT   = 32'd1664525;
    localparam logic [SEED_W-1:0] SEED_RESET = 32'd12345;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [SEED_W-1:0] t_seed;
    typedef logic [POS_W-1:0]  t_pos;

    localparam t_cmd CMD_LOAD    = 2'd0;
    localparam t_cmd CMD_SHUFFLE = 2'd1;
    localparam t_cmd CMD_READ    = 2'd2;

endpackage

>>> rtl/lfys_if.sv
interface lfys_req_if
    import lfys_pkg::*;
;
    logic  valid;
    logic  ready;
    t_cmd  command;
    t_seed seed_value;
    t_pos  lower_bound;
    t_pos  upper_bound;
    t_pos  read_index;

    modport source (
        output valid, command, seed_value, lower_bound, upper_bound, read_index,
        input  ready
    );
    modport sink (
        input  valid, command, seed_value, lower_bound, upper_bound, read_index,
        output ready
    );
endinterface

interface lfys_rsp_if
    import lfys_pkg::*;
;
    logic  valid;
    logic  ready;
    t_pos  entry_value;
    t_seed seed_now;

    modport source (
        output valid, entry_value, seed_now,
        input  ready
    );
    modport sink (
        input  valid, entry_value, seed_now,
        output ready
    );
endinterface

>>> rtl/lcg_fisher_yates_shuffler.sv
// channel   dir   handshake            payload
// i_req     in    valid/ready          command, seed_value, lower_bound, upper_bound, read_index
// o_rsp     out   valid/ready          entry_value, seed_now
//
// One request at a time; i_req.ready is high only when idle and the response slot is free.
// Load and unused commands answer in the next cycle, a read after S_RDCMD and S_RDOUT.
// A shuffle of n positions fills them with their indices (S_FILL), then per position does a
// seed multiply (S_STEP), offset multiply (S_KMUL), two-port table read (S_RD) and two writes
// through the single write port (S_WRI, S_WRJ), then answers. One multiplier serves both.
// Synchronous active-low reset sets the seed to 12345; the table stays unwritten.
// A stalled o_rsp holds its response and blocks new requests.
module lcg_fisher_yates_shuffler
    import lfys_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lfys_req_if.sink    i_req,
    lfys_rsp_if.source  o_rsp
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [SEED_W-1:0] DEPTH_W  = SEED_W'(TABLE_DEPTH);
    localparam logic [POS_W-1:0]  LAST_POS = POS_W'(TABLE_DEPTH - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FILL   = 4'd1;
    localparam logic [3:0] S_STEP   = 4'd2;
    localparam logic [3:0] S_KMUL   = 4'd3;
    localparam logic [3:0] S_RD     = 4'd4;
    localparam logic [3:0] S_WRI    = 4'd5;
    localparam logic [3:0] S_WRJ    = 4'd6;
    localparam logic [3:0] S_RDCMD  = 4'd7;
    localparam logic [3:0] S_RDOUT  = 4'd8;

    t_pos r_mem [TABLE_DEPTH];

    logic [3:0] r_state, n_state;
    t_seed      r_seed, n_seed;
    t_pos       r_i, n_i;
    t_pos       r_j, n_j;
    t_pos       r_lo, n_lo;
    t_pos       r_hi, n_hi;
    logic       r_rd_ok, n_rd_ok;
    logic       r_out_valid, n_out_valid;
    t_pos       r_out_entry, n_out_entry;
    t_seed      r_out_seed, n_out_seed;
    t_pos       r_rd_a, r_rd_b;

    logic       w_accept;
    t_pos       w_hi_sat;
    logic [POS_W:0]          w_span;
    t_seed      w_mul_a;
    t_seed      w_mul_b;
    logic [2*SEED_W-1:0]     w_prod;
    t_seed      w_seed_next;
    logic       w_we;
    t_pos       w_waddr;
    t_pos       w_wdata;

    assign i_req.ready   = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept      = i_req.valid && i_req.ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.entry_value = r_out_entry;
    assign o_rsp.seed_now    = r_out_seed;

    assign w_hi_sat    = (SEED_W'(i_req.upper_bound) >= DEPTH_W) ? LAST_POS : i_req.upper_bound;
    assign w_span      = (POS_W+1)'(r_hi) + (POS_W+1)'(1) - (POS_W+1)'(r_i);
    assign w_mul_a     = (r_state == S_KMUL) ? SEED_W'(w_span) : r_seed;
    assign w_mul_b     = (r_state == S_KMUL) ? r_seed : LCG_MULT;
    assign w_prod      = (2*SEED_W)'(w_mul_a) * (2*SEED_W)'(w_mul_b);
    assign w_seed_next = w_prod[SEED_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_seed      = r_seed;
        n_i         = r_i;
        n_j         = r_j;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_rd_ok     = r_rd_ok;
        n_out_valid = r_out_valid;
        n_out_entry = r_out_entry;
        n_out_seed  = r_out_seed;
        w_we        = 1'b0;
        w_waddr     = r_i;
        w_wdata     = r_i;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req.command)
                        CMD_LOAD: begin
                            n_seed      = i_req.seed_value;
                            n_out_valid = 1'b1;
                            n_out_entry = '0;
                            n_out_seed  = i_req.seed_value;
                        end
                        CMD_SHUFFLE: begin
                            if (i_req.lower_bound > w_hi_sat) begin
                                n_out_valid = 1'b1;
                                n_out_entry = '0;
                                n_out_seed  = r_seed;
                            end else begin
                                n_i     = i_req.lower_bound;
                                n_lo    = i_req.lower_bound;
                                n_hi    = w_hi_sat;
                                n_state = S_FILL;
                            end
                        end
                        CMD_READ: begin
                            n_i     = i_req.read_index;
                            n_rd_ok = SEED_W'(i_req.read_index) < DEPTH_W;
                            n_state = S_RDCMD;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_entry = '0;
                            n_out_seed  = r_seed;
                        end
                    endcase
                end
            end
            S_FILL: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = r_i;
                if (r_i == r_hi) begin
                    n_i     = r_lo;
                    n_state = S_STEP;
                end else begin
                    n_i = r_i + POS_W'(1);
                end
            end
            S_STEP: begin
                n_seed  = w_seed_next;
                n_state = S_KMUL;
            end
            S_KMUL: begin
                n_j     = r_i + w_prod[POS_W+SEED_W-1:SEED_W];
                n_state = S_RD;
            end
            S_RD: begin
                n_state = S_WRI;
            end
            S_WRI: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = r_rd_b;
                n_state = S_WRJ;
            end
            S_WRJ: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_rd_a;
                if (r_i == r_hi) begin
                    n_out_valid = 1'b1;
                    n_out_entry = '0;
                    n_out_seed  = r_seed;
                    n_state     = S_IDLE;
                end else begin
                    n_i     = r_i + POS_W'(1);
                    n_state = S_STEP;
                end
            end
            S_RDCMD: begin
                n_state = S_RDOUT;
            end
            S_RDOUT: begin
                n_out_valid = 1'b1;
                n_out_entry = r_rd_ok ? r_rd_a : '0;
                n_out_seed  = r_seed;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[AW'(w_waddr)] <= w_wdata;
        end
        r_rd_a <= r_mem[AW'(r_i)];
        r_rd_b <= r_mem[AW'(r_j)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= SEED_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seed      <= n_seed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_j         <= n_j;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_rd_ok     <= n_rd_ok;
        r_out_entry <= n_out_entry;
        r_out_seed  <= n_out_seed;
    end

endmodule

>>> verif/lcg_fisher_yates_shuffler_tb.sv
`timescale 1ns / 100ps

module lcg_fisher_yates_shuffler_tb
    import lfys_pkg::*;
;

    localparam int unsigned TABLE_DEPTH    = 2048;
    localparam t_cmd        CMD_NONE       = 2'd3;
    localparam int unsigned IDLE_PCT       = 34;
    localparam int unsigned WATCHDOG_LIMIT = 60000;
    localparam int unsigned HOLD_CYCLES    = 600;
    localparam int unsigned HOLD_AT_RSP    = 25;
    localparam int unsigned STEADY_LO      = 70;
    localparam int unsigned STEADY_HI      = 100;
    localparam int unsigned RANDOM_REQS    = 120;
    localparam int unsigned TAIL_CYCLES    = 20;

    typedef struct {
        t_cmd  command;
        t_seed seed_value;
        t_pos  lower_bound;
        t_pos  upper_bound;
        t_pos  read_index;
        bit    drain;
    } t_req;

    typedef struct {
        t_cmd  command;
        t_pos  entry_value;
        t_seed seed_now;
    } t_rsp;

    logic i_clk;
    logic i_rst_n;

    lfys_req_if req_if ();
    lfys_rsp_if rsp_if ();

    lcg_fisher_yates_shuffler #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_req        req_q[$];
    t_rsp        awaited_rsp_q[$];
    t_seed       model_seed;
    t_pos        model_tab [TABLE_DEPTH];
    bit          written_map [TABLE_DEPTH];
    int unsigned n_err, n_req, n_rsp, n_load, n_shuffle, n_read, n_pos, idle_cycles;
    int unsigned hold_left;
    bit          hold_done;
    bit          req_fire, rsp_fire, traffic_done;

    always #4 i_clk = ~i_clk;

    function automatic t_rsp compute_response(t_req r);
        t_rsp        e;
        int unsigned lo, hi, j;
        logic [63:0] prod;
        t_pos        tmp;
        e.command     = r.command;
        e.entry_value = '0;
        case (r.command)
            CMD_LOAD: begin
                model_seed = r.seed_value;
            end
            CMD_SHUFFLE: begin
                lo = 32'(r.lower_bound);
                hi = 32'(r.upper_bound);
                if (hi >= TABLE_DEPTH)
                    hi = TABLE_DEPTH - 1;
                if (lo <= hi) begin
                    for (int unsigned p = lo; p <= hi; p++)
                        model_tab[p] = t_pos'(p);
                    for (int unsigned p = lo; p <= hi; p++) begin
                        model_seed = model_seed * LCG_MULT;
                        prod = 64'(hi + 1 - p) * 64'(model_seed);
                        j = p + prod[63:32];
                        if (j > hi)
                            j = hi;
                        tmp          = model_tab[p];
                        model_tab[p] = model_tab[j];
                        model_tab[j] = tmp;
                    end
                end
            end
            CMD_READ: begin
                if (32'(r.read_index) < TABLE_DEPTH)
                    e.entry_value = model_tab[r.read_index];
            end
            default: ;
        endcase
        e.seed_now = model_seed;
        return e;
    endfunction

    task automatic queue_request(t_cmd c, t_seed s, t_pos lo, t_pos hi, t_pos idx, bit drain);
        t_req r;
        r = '{c, s, lo, hi, idx, drain};
        if (c == CMD_SHUFFLE && lo <= hi)
            for (int unsigned p = 32'(lo); p <= 32'(hi); p++)
                written_map[p] = 1'b1;
        req_q.push_back(r);
    endtask

    // request driver
    always @(negedge i_clk) begin
        t_req nxt;
        bit   offer;
        if (i_rst_n && !(req_if.valid && !req_fire)) begin
            offer = req_q.size() != 0 && !(req_q[0].drain && awaited_rsp_q.size() != 0);
            if (offer && !((n_req >= STEADY_LO && n_req < STEADY_HI) || hold_left != 0)
                    && $urandom_range(0, 99) < IDLE_PCT)
                offer = 1'b0;
            if (offer) begin
                nxt = req_q.pop_front();
                req_if.valid       <= 1'b1;
                req_if.command     <= nxt.command;
                req_if.seed_value  <= nxt.seed_value;
                req_if.lower_bound <= nxt.lower_bound;
                req_if.upper_bound <= nxt.upper_bound;
                req_if.read_index  <= nxt.read_index;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // response sink, with one long hold-off
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                rsp_if.ready <= 1'b0;
            end else if (!hold_done && n_rsp == HOLD_AT_RSP) begin
                hold_left    <= HOLD_CYCLES;
                hold_done    <= 1'b1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= (n_rsp >= STEADY_LO && n_rsp < STEADY_HI)
                                || $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        t_rsp e;
        t_req a;
        req_fire = i_rst_n && req_if.valid && req_if.ready;
        rsp_fire = i_rst_n && rsp_if.valid && rsp_if.ready;
        if (rsp_fire) begin
            n_rsp++;
            if (awaited_rsp_q.size() == 0) begin
                n_err++;
                $display("%0t: unexpected response entry_value=%0d seed_now=%h",
                         $time, rsp_if.entry_value, rsp_if.seed_now);
            end else begin
                e = awaited_rsp_q.pop_front();
                if (rsp_if.entry_value !== e.entry_value) begin
                    n_err++;
                    $display("%0t: entry_value mismatch (command %0d) expected %0d actual %0d",
                             $time, e.command, e.entry_value, rsp_if.entry_value);
                end
                if (rsp_if.seed_now !== e.seed_now) begin
                    n_err++;
                    $display("%0t: seed_now mismatch (command %0d) expected %h actual %h",
                             $time, e.command, e.seed_now, rsp_if.seed_now);
                end
            end
        end
        if (req_fire) begin
            n_req++;
            a = '{req_if.command, req_if.seed_value, req_if.lower_bound,
                  req_if.upper_bound, req_if.read_index, 1'b0};
            case (a.command)
                CMD_LOAD:    n_load++;
                CMD_SHUFFLE: begin
                    n_shuffle++;
                    if (a.lower_bound <= a.upper_bound)
                        n_pos += 32'(a.upper_bound) - 32'(a.lower_bound) + 1;
                end
                CMD_READ:    n_read++;
                default: ;
            endcase
            awaited_rsp_q.push_back(compute_response(a));
        end
        idle_cycles = (req_fire || rsp_fire) ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        if (i_rst_n && req_q.size() == 0 && !req_if.valid && awaited_rsp_q.size() == 0)
            traffic_done = 1'b1;
    end

    initial begin
        int unsigned pick, sz, span, lo, idx, n_directed;
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.command     = CMD_LOAD;
        req_if.seed_value  = '0;
        req_if.lower_bound = '0;
        req_if.upper_bound = '0;
        req_if.read_index  = '0;
        rsp_if.ready       = 1'b0;
        model_seed         = SEED_RESET;

        queue_request(CMD_NONE,    '0, '0, '0, '0, 1'b0);
        queue_request(CMD_SHUFFLE, '0, 11'd5, 11'd3, '0, 1'b0);
        queue_request(CMD_LOAD,    '0, '0, '0, '0, 1'b0);
        queue_request(CMD_SHUFFLE, '0, 11'd0, 11'd7, '0, 1'b0);
        queue_request(CMD_READ,    '0, '0, '0, 11'd0, 1'b0);
        queue_request(CMD_READ,    '0, '0, '0, 11'd7, 1'b0);
        queue_request(CMD_LOAD,    32'hFFFF_FFFF, '0, '0, '0, 1'b0);
        queue_request(CMD_SHUFFLE, '0, 11'd0, 11'd2047, '0, 1'b0);
        queue_request(CMD_READ,    '0, '0, '0, 11'd2047, 1'b0);
        queue_request(CMD_READ,    '0, '0, '0, 11'h555, 1'b0);
        queue_request(CMD_READ,    '0, '0, '0, 11'h2AA, 1'b0);
        queue_request(CMD_READ,    '0, '0, '0, 11'd1024, 1'b0);
        queue_request(CMD_SHUFFLE, '0, 11'd2047, 11'd2047, '0, 1'b0);
        queue_request(CMD_SHUFFLE, '0, 11'd0, 11'd0, '0, 1'b0);
        queue_request(CMD_LOAD,    SEED_RESET, '0, '0, '0, 1'b1);
        queue_request(CMD_SHUFFLE, '0, 11'd2040, 11'd2047, '0, 1'b0);
        queue_request(CMD_READ,    '0, '0, '0, 11'd2045, 1'b0);
        queue_request(CMD_SHUFFLE, '0, 11'd2047, 11'd0, '0, 1'b0);
        queue_request(CMD_NONE,    32'hFFFF_FFFF, 11'h7FF, 11'h7FF, 11'h7FF, 1'b0);
        queue_request(CMD_LOAD,    32'hA5A5_5A5A, '0, '0, '0, 1'b0);
        queue_request(CMD_SHUFFLE, '0, 11'd1000, 11'd1063, '0, 1'b0);
        queue_request(CMD_READ,    '0, '0, '0, 11'd1031, 1'b1);
        n_directed = req_q.size();

        while (req_q.size() < n_directed + RANDOM_REQS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                if ($urandom_range(0, 1))
                    queue_request(CMD_LOAD, $urandom(), t_pos'($urandom()),
                                  t_pos'($urandom()), t_pos'($urandom()),
                                  $urandom_range(0, 9) == 0);
                sz   = $urandom_range(0, 99);
                span = sz < 85 ? $urandom_range(1, 32) :
                       sz < 98 ? $urandom_range(33, 400) : TABLE_DEPTH;
                lo   = $urandom_range(0, TABLE_DEPTH - span);
                queue_request(CMD_SHUFFLE, $urandom(), t_pos'(lo), t_pos'(lo + span - 1),
                              t_pos'($urandom()), 1'b0);
                repeat ($urandom_range(1, 4))
                    queue_request(CMD_READ, $urandom(), t_pos'($urandom()),
                                  t_pos'($urandom()),
                                  t_pos'(lo + $urandom_range(0, span - 1)), 1'b0);
            end else if (pick == 7) begin
                queue_request(CMD_NONE, $urandom(), t_pos'($urandom()), t_pos'($urandom()),
                              t_pos'($urandom()), 1'b0);
            end else if (pick == 8) begin
                lo = $urandom_range(1, TABLE_DEPTH - 1);
                queue_request(CMD_SHUFFLE, $urandom(), t_pos'(lo),
                              t_pos'($urandom_range(0, lo - 1)), t_pos'($urandom()), 1'b0);
            end else begin
                // only entries already written by a shuffle
                idx = $urandom_range(0, TABLE_DEPTH - 1);
                while (!written_map[idx])
                    idx = $urandom_range(0, TABLE_DEPTH - 1);
                queue_request(CMD_READ, $urandom(), t_pos'($urandom()), t_pos'($urandom()),
                              t_pos'(idx), $urandom_range(0, 9) == 0);
            end
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (traffic_done);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests: %0d loads, %0d shuffles over %0d positions, %0d reads",
                 n_req, n_load, n_shuffle, n_pos, n_read);
        $display("Responses checked: %0d, mismatches: %0d, receiver hold-off of %0d cycles",
                 n_rsp, n_err, HOLD_CYCLES);
        if (n_err == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
